[rtl/ppm_pkg.sv]
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants for the position PID move core
// Item formats, configuration record, queue command and helper function.
// ----------------------------------------------------------------------------
package ppm_pkg;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_I         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_SETTLE_ERROR   = 3'd4,
    CFG_SETTLE_SPEED   = 3'd5
  } ppm_cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // distance in 1/256 inch to Q12 turns: round(dist * 200 / 157)
  localparam int          DIST_SCALE = 200;
  localparam int          DIST_HALF  = 78;            // floor(157 / 2)
  localparam logic [31:0] DIST_RECIP = 32'd3501629388; // ceil(2^39 / 157)
  localparam int          DIST_SHIFT = 39;
  localparam int          DIST_Q_W   = 24;

  // drive scaling and saturation
  localparam int DRIVE_SHIFT  = 12;
  localparam int DRIVE_MAX_MV = 12000;

  // front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic              req_type;
    logic signed [23:0] move_distance;
    logic signed [31:0] wheel_position;
    logic signed [7:0]  wheel_speed;
  } ppm_in_t;

  typedef struct packed {
    logic signed [14:0] drive_mv;
    logic               move_done;
  } ppm_out_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [23:0] integral_limit;
    logic [15:0] settle_error;
    logic [6:0]  settle_speed;
  } ppm_cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               is_start;
    logic               speed_ok;
    logic signed [31:0] wheel_position;
    logic signed [31:0] target;
    logic signed [31:0] start_err;
  } ppm_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

[rtl/position_pid_move_core.sv]
// ----------------------------------------------------------------------------
// position_pid_move_core: positional PID controller for one wheel move
// Start items set a target and start error; tick items produce a saturated
// PID drive in millivolts, or done once the move has settled.
// ----------------------------------------------------------------------------
//   channel   ports                              direction
//   ------    ---------------------------------  ---------
//   input     in_valid, in_ready, in_data        in
//   result    out_valid, out_ready, out_data     out
//   config    cfg_we, cfg_index, cfg_wdata       in (write only)
//
// One item per cycle sustained while the output is not stalled and the queue
// has room; every item gives one result (four front stages, queue, six back stages).
// The move state updates in one back stage per item, which sets the rate.
// Synchronous reset: registers to defaults, move state to zero and idle.
// A four-entry queue absorbs output stalls; in_ready drops only in reset or when
// the queue is full and the last front stage holds an item.
// ----------------------------------------------------------------------------
module position_pid_move_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ppm_pkg::ppm_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ppm_pkg::ppm_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  ppm_pkg::ppm_cfg_t cfg_r;
  ppm_pkg::ppm_cmd_t push_data, pop_data;
  logic              push, can_push, pop, not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= 16'd3000;
      cfg_r.gain_i         <= 16'd1000;
      cfg_r.gain_d         <= 16'd250;
      cfg_r.integral_limit <= 24'd204800;
      cfg_r.settle_error   <= 16'd410;
      cfg_r.settle_speed   <= 7'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        ppm_pkg::CFG_GAIN_P:         cfg_r.gain_p         <= cfg_wdata[15:0];
        ppm_pkg::CFG_GAIN_I:         cfg_r.gain_i         <= cfg_wdata[15:0];
        ppm_pkg::CFG_GAIN_D:         cfg_r.gain_d         <= cfg_wdata[15:0];
        ppm_pkg::CFG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_wdata[23:0];
        ppm_pkg::CFG_SETTLE_ERROR:   cfg_r.settle_error   <= cfg_wdata[15:0];
        ppm_pkg::CFG_SETTLE_SPEED:   cfg_r.settle_speed   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  ppm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .can_push  (can_push),
    .push      (push),
    .push_data (push_data)
  );

  ppm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  ppm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (not_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/ppm_front.sv]
// ----------------------------------------------------------------------------
// ppm_front: item intake and classification
// Converts a start distance to a target position and start error, tests the
// speed band, and pushes a command into the queue. Four stages, stall-all.
// ----------------------------------------------------------------------------
module ppm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  ppm_pkg::ppm_cfg_t cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  ppm_pkg::ppm_in_t  in_data,
  input  logic             can_push,
  output logic             push,
  output ppm_pkg::ppm_cmd_t push_data
);

  logic en;

  // stage 1: captured item
  logic             s1_v_r;
  ppm_pkg::ppm_in_t s1_d_r;

  // stage 2: distance magnitude, speed test
  logic               s2_v_r, s2_start_r, s2_neg_r, s2_ok_r;
  logic signed [31:0] s2_pos_r;
  logic [30:0]        s2_mag_r;
  logic signed [31:0] dist_x;
  logic [31:0]        dist_mag;
  logic signed [8:0]  spd_ext;
  logic signed [8:0]  spd_abs;
  logic [30:0]        s2_mag_nxt;
  logic               s2_ok_nxt;

  // stage 3: reciprocal multiply
  logic                          s3_v_r, s3_start_r, s3_neg_r, s3_ok_r;
  logic signed [31:0]            s3_pos_r;
  logic [ppm_pkg::DIST_Q_W-1:0]  s3_q_r;
  logic [62:0]                   prod;

  // stage 4: target
  logic               s4_v_r, s4_start_r, s4_ok_r;
  logic signed [31:0] s4_pos_r, s4_tgt_r;
  logic signed [24:0] off;
  logic signed [32:0] tgt_sum;
  logic signed [32:0] err_sum;

  assign en       = !s4_v_r || can_push;
  assign in_ready = rst_n && en;
  assign push     = s4_v_r && can_push;

  always_comb begin
    dist_x     = 32'($signed(s1_d_r.move_distance)) * 32'(ppm_pkg::DIST_SCALE);
    dist_mag   = dist_x[31] ? 32'(-dist_x) : 32'(dist_x);
    s2_mag_nxt = dist_mag[30:0] + 31'(ppm_pkg::DIST_HALF);
    spd_ext    = {s1_d_r.wheel_speed[7], s1_d_r.wheel_speed};
    spd_abs    = spd_ext[8] ? -spd_ext : spd_ext;
    s2_ok_nxt  = $unsigned(spd_abs) < {2'b00, cfg.settle_speed};
  end

  assign prod = 63'(s2_mag_r) * 63'(ppm_pkg::DIST_RECIP);

  always_comb begin
    off     = s3_neg_r ? -$signed({1'b0, s3_q_r}) : $signed({1'b0, s3_q_r});
    tgt_sum = $signed({s3_pos_r[31], s3_pos_r}) + $signed({{8{off[24]}}, off});
    err_sum = $signed({s4_tgt_r[31], s4_tgt_r}) - $signed({s4_pos_r[31], s4_pos_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r     <= in_data;
      s2_start_r <= (s1_d_r.req_type == ppm_pkg::REQ_START);
      s2_neg_r   <= dist_x[31];
      s2_ok_r    <= s2_ok_nxt;
      s2_pos_r   <= s1_d_r.wheel_position;
      s2_mag_r   <= s2_mag_nxt;
      s3_start_r <= s2_start_r;
      s3_neg_r   <= s2_neg_r;
      s3_ok_r    <= s2_ok_r;
      s3_pos_r   <= s2_pos_r;
      s3_q_r     <= prod[ppm_pkg::DIST_SHIFT +: ppm_pkg::DIST_Q_W];
      s4_start_r <= s3_start_r;
      s4_ok_r    <= s3_ok_r;
      s4_pos_r   <= s3_pos_r;
      s4_tgt_r   <= ppm_pkg::sat32(tgt_sum);
    end
  end

  always_comb begin
    push_data.is_start       = s4_start_r;
    push_data.speed_ok       = s4_ok_r;
    push_data.wheel_position = s4_pos_r;
    push_data.target         = s4_tgt_r;
    push_data.start_err      = ppm_pkg::sat32(err_sum);
  end

endmodule

[rtl/ppm_queue.sv]
// ----------------------------------------------------------------------------
// ppm_queue: command queue between front and back
// Small FIFO; full and empty come from a registered count.
// ----------------------------------------------------------------------------
module ppm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ppm_pkg::ppm_cmd_t push_data,
  output logic              can_push,
  input  logic              pop,
  output ppm_pkg::ppm_cmd_t pop_data,
  output logic              not_empty
);

  ppm_pkg::ppm_cmd_t         mem_r [ppm_pkg::QDEPTH];
  logic [ppm_pkg::QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [ppm_pkg::QAW:0]     count_r, count_nxt;

  assign can_push  = (count_r != (ppm_pkg::QAW+1)'(ppm_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/ppm_back.sv]
// ----------------------------------------------------------------------------
// ppm_back: PID execution pipeline
// Error, settle test and integral window, three gain multiplies, sum,
// rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module ppm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ppm_pkg::ppm_cfg_t cfg,
  input  logic              q_valid,
  input  ppm_pkg::ppm_cmd_t q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ppm_pkg::ppm_out_t out_data
);

  logic be;

  // move state
  logic signed [31:0] target_r;
  logic signed [31:0] start_error_r, start_error_nxt;
  logic signed [31:0] last_error_r, last_error_nxt;
  logic signed [31:0] prior_error_r, prior_error_nxt;
  logic signed [31:0] error_sum_r, error_sum_nxt;
  logic               moving_r, moving_nxt;

  // B1: error against current target
  logic               b1_v_r, b1_start_r, b1_ok_r;
  logic signed [31:0] b1_err_r, b1_se_r;
  logic signed [32:0] err_diff;

  // B2: state update
  logic               b2_v_r, b2_zero_r, b2_done_r;
  logic               b2_zero_nxt, b2_done_nxt;
  logic signed [31:0] b2_e_r, b2_sum_r;
  logic signed [32:0] b2_der_r;
  logic signed [32:0] last_ext, last_abs;
  logic               settled;
  logic signed [31:0] sum_raw, sum_new, lim_s;
  logic signed [35:0] e_ext, s_ext, e10;
  logic               int_reset, over;
  logic signed [32:0] der;

  // B3: products
  logic               b3_v_r, b3_zero_r, b3_done_r;
  logic signed [48:0] b3_pp_r, b3_pi_r;
  logic signed [49:0] b3_pd_r;

  // B4 / B5: sum
  logic               b4_v_r, b4_zero_r, b4_done_r;
  logic signed [50:0] b4_s_r;
  logic signed [49:0] b4_pd_r;
  logic               b5_v_r, b5_zero_r, b5_done_r;
  logic signed [50:0] b5_tot_r;

  // output
  logic               out_valid_r;
  ppm_pkg::ppm_out_t  out_data_r;
  logic signed [50:0] rnd, rq;
  logic signed [14:0] drive_sat;

  assign be        = !out_valid_r || out_ready;
  assign pop       = be && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign err_diff = $signed({target_r[31], target_r})
                  - $signed({q_data.wheel_position[31], q_data.wheel_position});

  // B2 combinational
  always_comb begin
    last_ext = {last_error_r[31], last_error_r};
    last_abs = last_ext[32] ? -last_ext : last_ext;
    settled  = ($unsigned(last_abs) < {17'd0, cfg.settle_error}) && b1_ok_r;

    sum_raw = ppm_pkg::sat32($signed({error_sum_r[31], error_sum_r})
                             + $signed({b1_err_r[31], b1_err_r}));
    e_ext   = {{4{b1_err_r[31]}}, b1_err_r};
    s_ext   = {{4{start_error_r[31]}}, start_error_r};
    e10     = (e_ext <<< 3) + (e_ext <<< 1);
    // window: nonpositive error, zero start error, or 10% or more remaining
    int_reset = b1_err_r[31] || (b1_err_r == '0) || (start_error_r == '0)
              || (!start_error_r[31] && (e10 >= s_ext));
    lim_s   = $signed({8'd0, cfg.integral_limit});
    over    = sum_raw > lim_s;
    sum_new = int_reset ? '0 : (over ? lim_s : sum_raw);
    der     = $signed({b1_err_r[31], b1_err_r})
            - $signed({prior_error_r[31], prior_error_r});

    start_error_nxt = start_error_r;
    last_error_nxt  = last_error_r;
    prior_error_nxt = prior_error_r;
    error_sum_nxt   = error_sum_r;
    moving_nxt      = moving_r;
    b2_zero_nxt     = 1'b1;
    b2_done_nxt     = 1'b1;

    if (b1_v_r) begin
      if (b1_start_r) begin
        start_error_nxt = b1_se_r;
        last_error_nxt  = b1_se_r;
        prior_error_nxt = '0;
        error_sum_nxt   = '0;
        moving_nxt      = 1'b1;
        b2_done_nxt     = 1'b0;
      end else if (!moving_r) begin
        b2_done_nxt = 1'b1;
      end else if (settled) begin
        moving_nxt = 1'b0;
      end else begin
        error_sum_nxt   = sum_new;
        prior_error_nxt = b1_err_r;
        last_error_nxt  = b1_err_r;
        b2_zero_nxt     = 1'b0;
        b2_done_nxt     = 1'b0;
      end
    end
  end

  // output rounding: half away from zero, then clamp
  always_comb begin
    rnd = b5_tot_r + (b5_tot_r[50] ? 51'sd2047 : 51'sd2048);
    rq  = rnd >>> ppm_pkg::DRIVE_SHIFT;
    if (rq > 51'(ppm_pkg::DRIVE_MAX_MV)) begin
      drive_sat = 15'(ppm_pkg::DRIVE_MAX_MV);
    end else if (rq < -51'(ppm_pkg::DRIVE_MAX_MV)) begin
      drive_sat = -15'(ppm_pkg::DRIVE_MAX_MV);
    end else begin
      drive_sat = rq[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= '0;
      start_error_r <= '0;
      last_error_r  <= '0;
      prior_error_r <= '0;
      error_sum_r   <= '0;
      moving_r      <= 1'b0;
      b1_v_r        <= 1'b0;
      b2_v_r        <= 1'b0;
      b3_v_r        <= 1'b0;
      b4_v_r        <= 1'b0;
      b5_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (be) begin
      if (pop && q_data.is_start) target_r <= q_data.target;
      start_error_r <= start_error_nxt;
      last_error_r  <= last_error_nxt;
      prior_error_r <= prior_error_nxt;
      error_sum_r   <= error_sum_nxt;
      moving_r      <= moving_nxt;
      b1_v_r        <= pop;
      b2_v_r        <= b1_v_r;
      b3_v_r        <= b2_v_r;
      b4_v_r        <= b3_v_r;
      b5_v_r        <= b4_v_r;
      out_valid_r   <= b5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      b1_start_r <= q_data.is_start;
      b1_ok_r    <= q_data.speed_ok;
      b1_se_r    <= q_data.start_err;
      b1_err_r   <= ppm_pkg::sat32(err_diff);

      b2_zero_r  <= b2_zero_nxt;
      b2_done_r  <= b2_done_nxt;
      b2_e_r     <= b1_err_r;
      b2_sum_r   <= sum_new;
      b2_der_r   <= der;

      b3_zero_r  <= b2_zero_r;
      b3_done_r  <= b2_done_r;
      b3_pp_r    <= b2_e_r * $signed({1'b0, cfg.gain_p});
      b3_pi_r    <= b2_sum_r * $signed({1'b0, cfg.gain_i});
      b3_pd_r    <= b2_der_r * $signed({1'b0, cfg.gain_d});

      b4_zero_r  <= b3_zero_r;
      b4_done_r  <= b3_done_r;
      b4_s_r     <= 51'(b3_pp_r) + 51'(b3_pi_r);
      b4_pd_r    <= b3_pd_r;

      b5_zero_r  <= b4_zero_r;
      b5_done_r  <= b4_done_r;
      b5_tot_r   <= b4_s_r + 51'(b4_pd_r);

      out_data_r.drive_mv  <= b5_zero_r ? '0 : drive_sat;
      out_data_r.move_done <= b5_done_r;
    end
  end

endmodule

[rtl/ppm_checker.sv]
// ----------------------------------------------------------------------------
// ppm_checker: port-level checks for the position PID move core
// Result hold under stall, drive range, done implies zero drive, reset.
// ----------------------------------------------------------------------------
module ppm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ppm_pkg::ppm_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.drive_mv) <= 15'sd12000)
               && ($signed(out_data.drive_mv) >= -15'sd12000))
    else $error("drive outside +/-12 V");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.move_done |-> out_data.drive_mv == '0)
    else $error("done item with nonzero drive");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |-> !in_ready)
    else $error("ready during reset");

endmodule

bind position_pid_move_core ppm_checker u_ppm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
